// ===== rtl/bmm_pkg.sv =====
package bmm_pkg;

    // Field widths fixed by the interface.
    localparam int IdW    = 4;
    localparam int CfgAW  = 1;
    localparam int CfgDW  = 5;
    localparam int CountW = 5;

    // Configuration register indexes.
    localparam logic [CfgAW-1:0] RegUserCount = 1'd0;
    localparam logic [CfgAW-1:0] RegMethod    = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_user;
        logic adj_rd;
        logic pop;
        logic mark;
        logic push;
        logic unwind_start;
        logic unwind_step;
        logic take;
        logic count_inc;
        logic next_user;
        logic clear_all;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic method;
        logic user_end;
        logic list_end;
        logic sp_one;
        logic stack_full;
        logic seen;
        logic owned;
        logic k_one;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/bmm_datapath.sv =====
module bmm_datapath #(
    parameter int MAX_USERS  = 16,
    parameter int MAX_JOBS   = 16,
    parameter int MAX_DEGREE = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bmm_pkg::t_cmd               i_cmd,
    output bmm_pkg::t_sts               o_sts,
    input  logic [bmm_pkg::IdW-1:0]     i_user_id,
    input  logic [bmm_pkg::IdW-1:0]     i_job_id,
    input  logic                        i_cfg_we,
    input  logic [bmm_pkg::CfgAW-1:0]   i_cfg_addr,
    input  logic [bmm_pkg::CfgDW-1:0]   i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bmm_pkg::CountW-1:0]  o_match_count,
    output logic                        o_overflow
);

    localparam int UW  = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = $clog2(MAX_USERS * MAX_DEGREE);
    localparam int SD  = MAX_JOBS + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int CW  = $clog2(MAX_USERS + 1);

    // Control state.
    logic [CW-1:0]              r_user;
    logic [CW-1:0]              r_count;
    logic [LW-1:0]              r_pos;
    logic [SPW-1:0]             r_sp;
    logic [SPW-1:0]             r_k;
    logic [LW-1:0]              r_len [MAX_USERS];
    logic                       r_own_vld [MAX_JOBS];
    logic                       r_visited [MAX_JOBS];
    logic                       r_dropped;
    logic [bmm_pkg::CfgDW-1:0]  r_user_count;
    logic                       r_method;
    logic                       r_out_valid;

    // Payload state.
    logic [JW-1:0]              r_adj [MAX_USERS * MAX_DEGREE];
    logic [JW-1:0]              r_adj_q;
    logic [UW-1:0]              r_own_user [MAX_JOBS];
    logic [UW-1:0]              r_stk_user [SD];
    logic [LW-1:0]              r_stk_pos [SD];
    logic [JW-1:0]              r_stk_job [SD];
    logic [bmm_pkg::CountW-1:0] r_out_count;
    logic                       r_out_ovf;

    logic [SIW-1:0] w_idx;
    logic [SIW-1:0] w_uidx;
    logic [UW-1:0]  w_in_user;
    logic [JW-1:0]  w_in_job;
    logic           w_in_ok;
    logic [LW-1:0]  w_ld_len;
    logic [UW-1:0]  w_len_user;
    logic [LW-1:0]  w_len;
    logic [LW-1:0]  w_cur_pos;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;
    logic [JW-1:0]  w_j;
    int             w_n;

    // Stack frames in use: the top, and the unwind cursor.
    assign w_idx  = SIW'(r_sp - 1'b1);
    assign w_uidx = SIW'(r_k - 1'b1);

    assign w_in_user = UW'(i_user_id);
    assign w_in_job  = JW'(i_job_id);
    assign w_in_ok   = (int'(i_user_id) < MAX_USERS) && (int'(i_job_id) < MAX_JOBS);
    assign w_j       = r_adj_q;
    assign w_ld_len  = r_len[w_in_user];

    // List length for the search: the greedy user or the search top.
    always_comb begin
        if (r_method) begin
            w_len_user = UW'(r_user);
        end else begin
            w_len_user = r_stk_user[w_idx];
        end
    end
    assign w_len     = r_len[w_len_user];
    assign w_cur_pos = r_method ? r_pos : r_stk_pos[w_idx];
    assign w_wr_addr = AW'(int'(w_in_user) * MAX_DEGREE + int'(w_ld_len));
    assign w_rd_addr = AW'(int'(w_len_user) * MAX_DEGREE + int'(w_cur_pos));
    assign w_n       = (int'(r_user_count) > MAX_USERS) ? MAX_USERS : int'(r_user_count);

    // Status to the controller.
    always_comb begin
        o_sts.method     = r_method;
        o_sts.user_end   = int'(r_user) >= w_n;
        o_sts.list_end   = w_cur_pos >= w_len;
        o_sts.sp_one     = r_sp == SPW'(1);
        o_sts.stack_full = r_sp == SPW'(SD);
        o_sts.seen       = r_visited[w_j];
        o_sts.owned      = r_own_vld[w_j];
        o_sts.k_one      = r_k == SPW'(1);
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    // Control registers, counters and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user       <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_sp         <= '0;
            r_k          <= '0;
            r_dropped    <= 1'b0;
            r_user_count <= bmm_pkg::CfgDW'(16);
            r_method     <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < MAX_USERS; i++) r_len[i] <= '0;
            for (int i = 0; i < MAX_JOBS; i++) begin
                r_own_vld[i] <= 1'b0;
                r_visited[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bmm_pkg::RegUserCount: r_user_count <= i_cfg_data;
                    bmm_pkg::RegMethod:    r_method     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.load && w_in_ok) begin
                if (int'(w_ld_len) < MAX_DEGREE) begin
                    r_len[w_in_user] <= w_ld_len + 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.start_user) begin
                r_sp  <= SPW'(1);
                r_pos <= '0;
                for (int i = 0; i < MAX_JOBS; i++) r_visited[i] <= 1'b0;
            end
            if (i_cmd.adj_rd && r_method) r_pos <= r_pos + 1'b1;
            if (i_cmd.pop) r_sp <= r_sp - 1'b1;
            if (i_cmd.push) r_sp <= r_sp + 1'b1;
            if (i_cmd.mark) r_visited[w_j] <= 1'b1;
            if (i_cmd.unwind_start) r_k <= r_sp;
            if (i_cmd.unwind_step) begin
                r_own_vld[r_stk_job[w_uidx]] <= 1'b1;
                r_k <= r_k - 1'b1;
            end
            if (i_cmd.take) r_own_vld[w_j] <= 1'b1;
            if (i_cmd.count_inc) r_count <= r_count + 1'b1;
            if (i_cmd.next_user) r_user <= r_user + 1'b1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear_all) begin
                r_user    <= '0;
                r_count   <= '0;
                r_dropped <= 1'b0;
                for (int i = 0; i < MAX_USERS; i++) r_len[i] <= '0;
                for (int i = 0; i < MAX_JOBS; i++) r_own_vld[i] <= 1'b0;
            end
        end
    end

    // Adjacency memory, owners, search stack and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_ok && int'(w_ld_len) < MAX_DEGREE) begin
            r_adj[w_wr_addr] <= w_in_job;
        end
        if (i_cmd.adj_rd) begin
            r_adj_q <= r_adj[w_rd_addr];
            if (!r_method) r_stk_pos[w_idx] <= r_stk_pos[w_idx] + 1'b1;
        end
        if (i_cmd.start_user) begin
            r_stk_user[0] <= UW'(r_user);
            r_stk_pos[0]  <= '0;
            r_stk_job[0]  <= '0;
        end
        if (i_cmd.mark) r_stk_job[w_idx] <= w_j;
        if (i_cmd.push) begin
            r_stk_user[SIW'(r_sp)] <= r_own_user[w_j];
            r_stk_pos[SIW'(r_sp)]  <= '0;
            r_stk_job[SIW'(r_sp)]  <= '0;
        end
        if (i_cmd.unwind_step) r_own_user[r_stk_job[w_uidx]] <= r_stk_user[w_uidx];
        if (i_cmd.take) r_own_user[w_j] <= UW'(r_user);
        if (i_cmd.out_load) begin
            r_out_count <= bmm_pkg::CountW'(r_count);
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_overflow    = r_out_ovf;

`ifndef NO_ASSERTIONS
    // The search stack never grows past one frame per job plus the root.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sp) <= SD) else $error("search stack overrun");

    // No more matches than users.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_USERS) else $error("match count beyond user count");

    // A loaded result is presented on the next cycle.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid) else $error("result not presented");
`endif

endmodule

// ===== rtl/bmm_ctrl.sv =====
module bmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_ready,
    input  bmm_pkg::t_sts i_sts,
    output bmm_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_USER   = 8'b0000_0010,
        S_TOP    = 8'b0000_0100,
        S_EXAM   = 8'b0000_1000,
        S_UNWIND = 8'b0001_0000,
        S_GRD_RD = 8'b0010_0000,
        S_GRD_CK = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = S_USER;
                end
            end
            S_USER: begin
                if (i_sts.user_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_user = 1'b1;
                    n_state = i_sts.method ? S_GRD_RD : S_TOP;
                end
            end
            S_TOP: begin
                if (i_sts.list_end) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.sp_one) begin
                        o_cmd.next_user = 1'b1;
                        n_state = S_USER;
                    end
                end else begin
                    o_cmd.adj_rd = 1'b1;
                    n_state = S_EXAM;
                end
            end
            S_EXAM: begin
                n_state = S_TOP;
                if (!i_sts.seen) begin
                    o_cmd.mark = 1'b1;
                    if (!i_sts.owned) begin
                        o_cmd.unwind_start = 1'b1;
                        n_state = S_UNWIND;
                    end else if (!i_sts.stack_full) begin
                        o_cmd.push = 1'b1;
                    end
                end
            end
            S_UNWIND: begin
                o_cmd.unwind_step = 1'b1;
                if (i_sts.k_one) begin
                    o_cmd.count_inc = 1'b1;
                    o_cmd.next_user = 1'b1;
                    n_state = S_USER;
                end
            end
            S_GRD_RD: begin
                if (i_sts.list_end) begin
                    o_cmd.next_user = 1'b1;
                    n_state = S_USER;
                end else begin
                    o_cmd.adj_rd = 1'b1;
                    n_state = S_GRD_CK;
                end
            end
            S_GRD_CK: begin
                if (!i_sts.owned) begin
                    o_cmd.take      = 1'b1;
                    o_cmd.count_inc = 1'b1;
                    o_cmd.next_user = 1'b1;
                    n_state = S_USER;
                end else begin
                    n_state = S_GRD_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.clear_all = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // Items are taken only while no run is under way.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready during a run");

    // The final item always starts a run.
    a_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> r_state == S_USER) else $error("run not started");

    // A result is loaded only when the output stage can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free) else $error("result overwritten");
`endif

endmodule

// ===== rtl/bipartite_max_matching_engine.sv =====
// Bipartite matching engine. Edges (user_id, job_id) are taken one item per
// cycle and appended to per-user lists of up to MAX_DEGREE jobs; an edge for a
// full list is dropped and flags overflow. The item with last set starts the
// computation over users 0..min(user_count,MAX_USERS)-1 and the input stalls
// until the result is loaded: method 0 runs a depth-first augmenting-path
// search per user, method 1 gives each user its first free listed job. Each
// examined list entry is an adjacency memory read, then a check, and the
// result is held back while the previous result is still waiting. A method 0
// search holds at most MAX_JOBS+1 frames, each popped or unwound once.
// The result is one item of match_count and overflow; lists and matching are
// cleared when it is emitted, while the configuration registers keep.
module bipartite_max_matching_engine #(
    parameter int MAX_USERS  = 16,
    parameter int MAX_JOBS   = 16,
    parameter int MAX_DEGREE = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bmm_pkg::IdW-1:0]     i_user_id,
    input  logic [bmm_pkg::IdW-1:0]     i_job_id,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bmm_pkg::CountW-1:0]  o_match_count,
    output logic                        o_overflow,
    input  logic                        i_cfg_we,
    input  logic [bmm_pkg::CfgAW-1:0]   i_cfg_addr,
    input  logic [bmm_pkg::CfgDW-1:0]   i_cfg_data
);

    bmm_pkg::t_cmd w_cmd;
    bmm_pkg::t_sts w_sts;

    // Sequencer.
    bmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Stores, counters and result register.
    bmm_datapath #(
        .MAX_USERS  (MAX_USERS),
        .MAX_JOBS   (MAX_JOBS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_user_id     (i_user_id),
        .i_job_id      (i_job_id),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count),
        .o_overflow    (o_overflow)
    );

endmodule

// ===== dv/tb.sv =====
module tb;

    localparam int NUM_USERS  = 16;
    localparam int NUM_JOBS   = 16;
    localparam int LIST_DEPTH = 16;
    localparam int STALL_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 50;

    // Clock and DUT ports.
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [bmm_pkg::IdW-1:0]       i_user_id;
    logic [bmm_pkg::IdW-1:0]       i_job_id;
    logic                          i_last;
    logic                          o_valid;
    logic                          i_ready;
    logic [bmm_pkg::CountW-1:0]    o_match_count;
    logic                          o_overflow;
    logic                          i_cfg_we;
    logic [bmm_pkg::CfgAW-1:0]     i_cfg_addr;
    logic [bmm_pkg::CfgDW-1:0]     i_cfg_data;

    bipartite_max_matching_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_user_id     (i_user_id),
        .i_job_id      (i_job_id),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count),
        .o_overflow    (o_overflow),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // One expected matching result.
    typedef struct packed {
        logic [bmm_pkg::CountW-1:0] count;
        logic                       ovf;
    } t_match_result;

    t_match_result pending_results[$];
    int  error_count;
    int  items_sent;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  quiet_cycles;

    // Shadow copy of the block's stores and registers.
    logic [bmm_pkg::IdW-1:0] edge_list[NUM_USERS][LIST_DEPTH];
    int             edge_len[NUM_USERS];
    int             job_holder[NUM_JOBS];
    bit             job_taken[NUM_JOBS];
    bit             job_seen[NUM_JOBS];
    bit             lost_edge;
    logic [bmm_pkg::CfgDW-1:0] users_reg;
    logic             greedy_reg;

    function automatic void clear_shadow();
        for (int u = 0; u < NUM_USERS; u++) edge_len[u] = 0;
        for (int j = 0; j < NUM_JOBS; j++) begin
            job_holder[j] = 0;
            job_taken[j]  = 1'b0;
        end
        lost_edge = 1'b0;
    endfunction

    // Depth-first augmenting path search from one user with an explicit stack.
    function automatic bit find_augmenting_path(int root);
        int fr_user[NUM_JOBS+1];
        int fr_pos[NUM_JOBS+1];
        int fr_job[NUM_JOBS+1];
        int sp;
        int u;
        int j;
        for (int k = 0; k < NUM_JOBS; k++) job_seen[k] = 1'b0;
        sp = 1;
        fr_user[0] = root;
        fr_pos[0]  = 0;
        fr_job[0]  = 0;
        while (sp > 0) begin
            u = fr_user[sp-1];
            if (fr_pos[sp-1] >= edge_len[u]) begin
                sp--;
                continue;
            end
            j = edge_list[u][fr_pos[sp-1]];
            fr_pos[sp-1]++;
            if (job_seen[j]) continue;
            job_seen[j] = 1'b1;
            fr_job[sp-1] = j;
            if (!job_taken[j]) begin
                // Flip the path: every frame takes the job it reached.
                for (int k = sp; k > 0; k--) begin
                    job_holder[fr_job[k-1]] = fr_user[k-1];
                    job_taken[fr_job[k-1]]  = 1'b1;
                end
                return 1'b1;
            end
            if (sp < NUM_JOBS + 1) begin
                fr_user[sp] = job_holder[j];
                fr_pos[sp]  = 0;
                fr_job[sp]  = 0;
                sp++;
            end
        end
        return 1'b0;
    endfunction

    // Apply one edge to the shadow state; returns 1 when a result is due.
    function automatic bit predict_edge(logic [bmm_pkg::IdW-1:0] user,
                                        logic [bmm_pkg::IdW-1:0] job,
                                        logic last, output t_match_result res);
        int n;
        int total;
        res = '0;
        if (edge_len[user] < LIST_DEPTH) begin
            edge_list[user][edge_len[user]] = job;
            edge_len[user]++;
        end else begin
            lost_edge = 1'b1;
        end
        if (!last) return 1'b0;
        n = (users_reg > NUM_USERS) ? NUM_USERS : int'(users_reg);
        total = 0;
        for (int u = 0; u < n; u++) begin
            if (!greedy_reg) begin
                if (find_augmenting_path(u)) total++;
            end else begin
                for (int p = 0; p < edge_len[u]; p++) begin
                    if (!job_taken[edge_list[u][p]]) begin
                        job_taken[edge_list[u][p]]  = 1'b1;
                        job_holder[edge_list[u][p]] = u;
                        total++;
                        break;
                    end
                end
            end
        end
        res.count = total[bmm_pkg::CountW-1:0];
        res.ovf   = lost_edge;
        clear_shadow();
        return 1'b1;
    endfunction

    // Send one edge; the expected result comes from the shadow or a typed value.
    task automatic send_edge(logic [bmm_pkg::IdW-1:0] user, logic [bmm_pkg::IdW-1:0] job,
                             logic last, bit use_typed, t_match_result typed);
        t_match_result res;
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_user_id <= user;
        i_job_id  <= job;
        i_last    <= last;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (predict_edge(user, job, last, res))
            pending_results.insert(pending_results.size(), use_typed ? typed : res);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(logic [bmm_pkg::CfgAW-1:0] addr,
                             logic [bmm_pkg::CfgDW-1:0] data);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == bmm_pkg::RegUserCount) users_reg = data;
        else greedy_reg = data[0];
    endtask

    // One random edge set closed by a last item.
    task automatic send_random_set();
        int n_edges;
        int span;
        int hot_user;
        bit flood;
        logic [bmm_pkg::IdW-1:0] user;
        logic [bmm_pkg::IdW-1:0] job;
        t_match_result none;
        none = '0;
        flood = ($urandom_range(9) == 0);
        n_edges = flood ? $urandom_range(17, 22) : $urandom_range(1, 14);
        span = (users_reg == 0) ? NUM_USERS : ((users_reg > NUM_USERS) ? NUM_USERS
                                                                       : int'(users_reg));
        hot_user = $urandom_range(span - 1);
        for (int i = 0; i < n_edges; i++) begin
            if (flood && $urandom_range(3) != 0) user = hot_user[bmm_pkg::IdW-1:0];
            else if ($urandom_range(4) != 0) user = bmm_pkg::IdW'($urandom_range(span - 1));
            else user = bmm_pkg::IdW'($urandom_range(NUM_USERS - 1));
            if ($urandom_range(1) == 0) job = bmm_pkg::IdW'($urandom_range(span - 1));
            else job = bmm_pkg::IdW'($urandom_range(NUM_JOBS - 1));
            send_edge(user, job, (i == n_edges - 1), 1'b0, none);
        end
    endtask

    // Receiver stalls.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result count=%0d ovf=%0b", $time,
                         o_match_count, o_overflow);
                error_count++;
            end else begin
                if (o_match_count !== pending_results[0].count) begin
                    $display("%0t: match_count expected %0d actual %0d", $time,
                             pending_results[0].count, o_match_count);
                    error_count++;
                end
                if (o_overflow !== pending_results[0].ovf) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             pending_results[0].ovf, o_overflow);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Directed edges: typed results where they are obvious.
    typedef struct {
        logic [bmm_pkg::IdW-1:0] user;
        logic [bmm_pkg::IdW-1:0] job;
        logic           last;
        bit             typed;
        t_match_result  res;
    } t_edge_row;

    t_edge_row directed[$];

    function automatic void add_row(logic [bmm_pkg::IdW-1:0] user,
                                    logic [bmm_pkg::IdW-1:0] job, logic last,
                                    bit typed, t_match_result res);
        t_edge_row row;
        row.user  = user;
        row.job   = job;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        directed.insert(directed.size(), row);
    endfunction

    initial begin
        logic [bmm_pkg::CfgDW-1:0] user_settings[9];
        logic             method_settings[9];
        int phase_items;
        user_settings   = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd1, 5'd6, 5'd17, 5'd16, 5'd10};
        method_settings = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        error_count  = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 18;
        rx_idle_pct  = 48;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_user_id  = '0;
        i_job_id   = '0;
        i_last     = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = bmm_pkg::RegUserCount;
        i_cfg_data = '0;
        users_reg  = 5'd16;
        greedy_reg = 1'b0;
        clear_shadow();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single edges at the id extremes, right after reset.
        add_row(4'd0, 4'd0, 1'b1, 1'b1, t_match_result'{5'd1, 1'b0});
        add_row(4'd15, 4'd15, 1'b1, 1'b1, t_match_result'{5'd1, 1'b0});
        // Duplicate edges count once.
        add_row(4'd1, 4'd4, 1'b0, 1'b0, t_match_result'{5'd0, 1'b0});
        add_row(4'd1, 4'd4, 1'b1, 1'b1, t_match_result'{5'd1, 1'b0});
        // One user's list filled, then one more edge is dropped.
        for (int i = 0; i < LIST_DEPTH; i++)
            add_row(4'd2, 4'(i), 1'b0, 1'b0, t_match_result'{5'd0, 1'b0});
        add_row(4'd2, 4'd7, 1'b1, 1'b1, t_match_result'{5'd1, 1'b1});
        // A conflict that needs an augmenting path.
        add_row(4'd0, 4'd3, 1'b0, 1'b0, t_match_result'{5'd0, 1'b0});
        add_row(4'd0, 4'd9, 1'b0, 1'b0, t_match_result'{5'd0, 1'b0});
        add_row(4'd1, 4'd3, 1'b1, 1'b1, t_match_result'{5'd2, 1'b0});
        foreach (directed[i])
            send_edge(directed[i].user, directed[i].job, directed[i].last,
                      directed[i].typed, directed[i].res);

        // Random phases across register settings, extremes included.
        for (int p = 0; p < 9; p++) begin
            write_reg(bmm_pkg::RegUserCount, user_settings[p]);
            write_reg(bmm_pkg::RegMethod, {4'd0, method_settings[p]});
            phase_items = 0;
            while (phase_items < 88) begin
                if (items_sent < 290) begin
                    tx_idle_pct = 18;
                    rx_idle_pct = 48;
                end else if (items_sent < 560) begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 18;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                phase_items -= items_sent;
                send_random_set();
                phase_items += items_sent;
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
